/* hdl/npci_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npci_pkg
// Shared types, constants and functions of the nearest palette color index
// block.
// ----------------------------------------------------------------------------
package npci_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COMP_W = 8;
    localparam int INDEX_W = 8;
    localparam int DIST_W = 18;

    typedef logic [COMP_W-1:0]  comp_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [DIST_W-1:0]  dist_t;

    // Three times the square of the largest component difference.
    localparam dist_t DIST_LIMIT = 18'd195075;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_PIXEL = 1'b1
    } kind_t;

    typedef struct packed {
        comp_t blue;
        comp_t green;
        comp_t red;
    } color_t;

    typedef struct packed {
        kind_t  kind;
        index_t entry_index;
        color_t pixel;
        index_t best_index;
        dist_t  best_dist;
        color_t best_color;
    } item_t;

    function automatic color_t default_color(index_t idx);
        color_t c;
        c.blue  = {idx[7:6], 6'b0};
        c.green = {idx[5:3], 5'b0};
        c.red   = {idx[2:0], 5'b0};
        return c;
    endfunction

    function automatic logic [2*COMP_W-1:0] sq_diff(comp_t a, comp_t b);
        comp_t d;
        d = (a > b) ? (a - b) : (b - a);
        return (2*COMP_W)'(d) * (2*COMP_W)'(d);
    endfunction

    function automatic dist_t color_dist(color_t a, color_t b);
        return DIST_W'(sq_diff(a.blue, b.blue)) + DIST_W'(sq_diff(a.green, b.green))
             + DIST_W'(sq_diff(a.red, b.red));
    endfunction

endpackage
`default_nettype wire

/* hdl/npci_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npci_cell
// One palette entry with its two pipeline stages. The first stage measures
// the distance from the passing pixel to the entry; the second keeps the
// better of that entry and the best match so far. A load item that names
// this entry overwrites it as the item passes.
// ----------------------------------------------------------------------------
module npci_cell #(
    parameter int INDEX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire npci_pkg::item_t in_item,
    output logic                 out_valid,
    output npci_pkg::item_t      out_item
);

    npci_pkg::color_t entry_reg;
    logic             v1_reg;
    logic             v2_reg;
    npci_pkg::item_t  it1_reg;
    npci_pkg::item_t  it2_reg;
    npci_pkg::item_t  it2_next;
    npci_pkg::dist_t  dist_reg;
    npci_pkg::dist_t  dist_next;
    npci_pkg::color_t cand_reg;
    logic             write_hit;

    assign dist_next = npci_pkg::color_dist(in_item.pixel, entry_reg);
    assign write_hit = en && in_valid && (in_item.kind == npci_pkg::KIND_LOAD)
                       && (in_item.entry_index == npci_pkg::INDEX_W'(INDEX));

    always_comb
    begin
        it2_next = it1_reg;
        if ((it1_reg.kind == npci_pkg::KIND_PIXEL)
            && ((INDEX == 0) || (dist_reg < it1_reg.best_dist)))
        begin
            it2_next.best_dist  = dist_reg;
            it2_next.best_index = npci_pkg::INDEX_W'(INDEX);
            it2_next.best_color = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= npci_pkg::default_color(npci_pkg::INDEX_W'(INDEX));
        end
        else if (write_hit)
        begin
            entry_reg <= in_item.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg  <= in_item;
            dist_reg <= dist_next;
            cand_reg <= entry_reg;
            it2_reg  <= it2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = it2_reg;

    a_entry_written: assert property (@(posedge clk) disable iff (!rst_n)
        write_hit |=> (entry_reg == $past(in_item.pixel)))
        else $error("palette entry not updated by a matching load item");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && (it2_reg.kind == npci_pkg::KIND_PIXEL))
        |-> (it2_reg.best_dist <= npci_pkg::DIST_LIMIT))
        else $error("best distance above the limit");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && v2_reg) |=> (v2_reg && $stable(it2_reg)))
        else $error("cell output changed while the pipeline was held");

endmodule
`default_nettype wire

/* hdl/nearest_palette_color_index_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_index_top
// Maps each pixel item to the palette entry with the smallest squared color
// distance, and takes load items that overwrite palette entries.
//
//   Channel  Handshake            Payload
//   input    in_valid, in_stall   kind, entry_index, blue, green, red
//   output   out_valid, out_stall match_index, mapped_blue, mapped_green,
//                                 mapped_red
//
// One item enters per cycle while in_stall is low. A pixel item passes through
// the chain of one two-stage cell per palette entry and then the output register.
// Load items travel down the same chain and write their entry on the way,
// so every pixel sees the palette as it stood when the pixel was accepted.
// Reset empties the pipeline and loads the default 4x8x8 color map.
// While a result waits at a stalled output, the whole chain holds.
// ----------------------------------------------------------------------------
module nearest_palette_color_index_top #(
    parameter int PALETTE_ENTRIES = npci_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  entry_index,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       match_index,
    output logic [7:0]       mapped_blue,
    output logic [7:0]       mapped_green,
    output logic [7:0]       mapped_red
);

    logic                  en;
    logic                  v_chain [0:PALETTE_ENTRIES];
    npci_pkg::item_t       it_chain [0:PALETTE_ENTRIES];
    npci_pkg::item_t       head_item;
    logic                  out_valid_reg;
    npci_pkg::index_t      match_index_reg;
    npci_pkg::color_t      mapped_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        head_item              = '0;
        head_item.kind         = npci_pkg::kind_t'(kind);
        head_item.entry_index  = entry_index;
        head_item.pixel.blue   = blue;
        head_item.pixel.green  = green;
        head_item.pixel.red    = red;
        head_item.best_index   = '0;
        head_item.best_dist    = npci_pkg::DIST_LIMIT;
    end

    assign v_chain[0]  = in_valid;
    assign it_chain[0] = head_item;

    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        npci_cell #(
            .INDEX(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v_chain[i]),
            .in_item  (it_chain[i]),
            .out_valid(v_chain[i+1]),
            .out_item (it_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_chain[PALETTE_ENTRIES]
                             && (it_chain[PALETTE_ENTRIES].kind == npci_pkg::KIND_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            match_index_reg <= it_chain[PALETTE_ENTRIES].best_index;
            mapped_reg      <= it_chain[PALETTE_ENTRIES].best_color;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_index  = match_index_reg;
    assign mapped_blue  = mapped_reg.blue;
    assign mapped_green = mapped_reg.green;
    assign mapped_red   = mapped_reg.red;

    a_load_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_chain[PALETTE_ENTRIES]
         && (it_chain[PALETTE_ENTRIES].kind == npci_pkg::KIND_LOAD)) |=> !out_valid_reg)
        else $error("a load item produced a result");

    a_match_in_palette: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(match_index_reg) < PALETTE_ENTRIES))
        else $error("match index beyond the palette");

    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(mapped_reg)))
        else $error("result changed while the output was stalled");

endmodule
`default_nettype wire

/* sim/palette_match_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_match_checker
// Watches both channels of the nearest palette color index block. It keeps
// its own copy of the palette and works out the winning entry for every
// accepted pixel item. It then compares each accepted result, field by field,
// with the oldest pending prediction.
// ----------------------------------------------------------------------------
module palette_match_checker #(
    parameter int ENTRIES = npci_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  entry_index,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  match_index,
    input  wire logic [7:0]  mapped_blue,
    input  wire logic [7:0]  mapped_green,
    input  wire logic [7:0]  mapped_red,
    output int               mismatches,
    output int               outstanding
);
    import npci_pkg::*;

    typedef struct packed {
        index_t index;
        color_t color;
    } match_t;

    localparam int REPORT_LIMIT = 10;

    color_t palette [ENTRIES];
    match_t expected_matches [$];

    function automatic color_t grid_color(int i);
        color_t c;
        c.blue  = comp_t'((i / 64) * 64);
        c.green = comp_t'(((i / 8) % 8) * 32);
        c.red   = comp_t'((i % 8) * 32);
        return c;
    endfunction

    function automatic int color_gap(color_t a, color_t b);
        int db;
        int dg;
        int dr;
        db = int'(a.blue) - int'(b.blue);
        dg = int'(a.green) - int'(b.green);
        dr = int'(a.red) - int'(b.red);
        return db * db + dg * dg + dr * dr;
    endfunction

    function automatic match_t nearest_entry(color_t px);
        match_t m;
        int gap;
        int best_gap;
        best_gap = int'(DIST_LIMIT);
        m.index = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            gap = color_gap(px, palette[k]);
            if (gap < best_gap)
            begin
                best_gap = gap;
                m.index = index_t'(k);
            end
        end
        m.color = palette[m.index];
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        match_t got;
        match_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                palette[i] = grid_color(i);
            expected_matches.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.index = match_index;
                got.color = {mapped_blue, mapped_green, mapped_red};
                if (expected_matches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Result with no pixel pending: index %0d bgr %0d/%0d/%0d",
                                 got.index, got.color.blue, got.color.green, got.color.red);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (got.index != want.index || got.color.blue != want.color.blue
                        || got.color.green != want.color.green
                        || got.color.red != want.color.red)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"Wrong result: expected index %0d bgr %0d/%0d/%0d,",
                                      " got index %0d bgr %0d/%0d/%0d"},
                                     want.index, want.color.blue, want.color.green,
                                     want.color.red, got.index, got.color.blue,
                                     got.color.green, got.color.red);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind_t'(kind) == KIND_PIXEL)
                    expected_matches.push_back(nearest_entry({blue, green, red}));
                else if (int'(entry_index) < ENTRIES)
                    palette[entry_index] = {blue, green, red};
            end
        end
        outstanding = expected_matches.size();
    end

endmodule

/* sim/nearest_palette_color_index_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_index_top_tb
// Drives load and pixel items into the nearest palette color index block:
// directed corner and tie cases on the default map and after loads, random
// traffic, and one-color palettes that leave the opposite corner at the limit.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module nearest_palette_color_index_top_tb;
    import npci_pkg::*;

    localparam int ENTRIES = PALETTE_ENTRIES_DEF;
    localparam int LATENCY = 2 * ENTRIES + 1;
    localparam int WATCHDOG_LIMIT = 8 * LATENCY;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    kind_t        kind = KIND_LOAD;
    logic [7:0]   entry_index = '0;
    logic [7:0]   blue = '0;
    logic [7:0]   green = '0;
    logic [7:0]   red = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [7:0]   match_index;
    logic [7:0]   mapped_blue;
    logic [7:0]   mapped_green;
    logic [7:0]   mapped_red;

    int           mismatches;
    int           outstanding;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           stall_phase = 0;
    stall_style_t stall_style = STALL_NONE;
    color_t       last_load = '0;

    nearest_palette_color_index_top #(
        .PALETTE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .entry_index(entry_index),
        .blue(blue),
        .green(green),
        .red(red),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .match_index(match_index),
        .mapped_blue(mapped_blue),
        .mapped_green(mapped_green),
        .mapped_red(mapped_red)
    );

    palette_match_checker #(
        .ENTRIES(ENTRIES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .entry_index(entry_index),
        .blue(blue),
        .green(green),
        .red(red),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .match_index(match_index),
        .mapped_blue(mapped_blue),
        .mapped_green(mapped_green),
        .mapped_red(mapped_red),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_phase == 0)
            begin
                stall_style <= stall_style_t'($urandom_range(0, 3));
                stall_phase <= $urandom_range(50, 400);
            end
            else
                stall_phase <= stall_phase - 1;
            case (stall_style)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= ((stall_phase % 8) < 3);
                default:        out_stall <= ($urandom_range(0, 9) < 6);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input kind_t k, input index_t idx, input color_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        entry_index <= idx;
        blue <= c.blue;
        green <= c.green;
        red <= c.red;
        do
            @(posedge clk);
        while (in_stall);
        if (k == KIND_LOAD)
            last_load = c;
    endtask

    function automatic comp_t pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return comp_t'($urandom_range(0, 7) * 32);
            3:       return comp_t'($urandom_range(0, 7) * 32 + 16);
            default: return comp_t'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        color_t c;
        for (int n = 0; n < count; n++)
        begin
            c.blue = pick_level();
            c.green = pick_level();
            c.red = pick_level();
            if ($urandom_range(0, 9) < 3)
                send_item(KIND_LOAD, index_t'($urandom), c);
            else if ($urandom_range(0, 9) == 0)
                send_item(KIND_PIXEL, index_t'($urandom), last_load);
            else
                send_item(KIND_PIXEL, index_t'($urandom), c);
        end
    endtask

    task automatic fill_palette(input color_t c);
        for (int i = 0; i < ENTRIES; i++)
            send_item(KIND_LOAD, index_t'(i), c);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners and halfway ties on the default map, then after loads.
        send_item(KIND_PIXEL, 8'd0, '{8'd0, 8'd0, 8'd0});
        send_item(KIND_PIXEL, 8'd255, '{8'd255, 8'd255, 8'd255});
        send_item(KIND_PIXEL, 8'd170, '{8'd16, 8'd16, 8'd16});
        send_item(KIND_PIXEL, 8'd85, '{8'd32, 8'd48, 8'd16});
        send_item(KIND_PIXEL, 8'd1, '{8'd96, 8'd80, 8'd240});
        send_item(KIND_PIXEL, 8'd254, '{8'd128, 8'd0, 8'd255});
        send_item(KIND_LOAD, 8'd0, '{8'd255, 8'd255, 8'd255});
        send_item(KIND_LOAD, 8'd255, '{8'd0, 8'd0, 8'd0});
        send_item(KIND_PIXEL, 8'd0, '{8'd0, 8'd0, 8'd0});
        send_item(KIND_PIXEL, 8'd255, '{8'd255, 8'd255, 8'd255});
        send_item(KIND_LOAD, 8'd128, '{8'h55, 8'hAA, 8'h55});
        send_item(KIND_LOAD, 8'd127, '{8'hAA, 8'h55, 8'hAA});
        send_item(KIND_PIXEL, 8'h0F, '{8'h55, 8'hAA, 8'h55});
        send_item(KIND_PIXEL, 8'hF0, '{8'hAA, 8'h55, 8'hAA});
        send_item(KIND_PIXEL, 8'd127, '{8'd1, 8'd254, 8'd1});
        send_item(KIND_LOAD, 8'd64, '{8'd17, 8'd17, 8'd17});
        send_item(KIND_LOAD, 8'd65, '{8'd17, 8'd17, 8'd17});
        send_item(KIND_PIXEL, 8'd3, '{8'd17, 8'd17, 8'd17});

        send_random(650);

        // With every entry at one corner, the opposite corner reaches no entry.
        fill_palette('{8'd0, 8'd0, 8'd0});
        send_item(KIND_PIXEL, 8'd77, '{8'd255, 8'd255, 8'd255});
        send_item(KIND_PIXEL, 8'd200, '{8'd0, 8'd0, 8'd0});
        send_item(KIND_PIXEL, 8'd9, '{8'd255, 8'd255, 8'd254});
        fill_palette('{8'd255, 8'd255, 8'd255});
        send_item(KIND_PIXEL, 8'd33, '{8'd0, 8'd0, 8'd0});
        send_item(KIND_PIXEL, 8'd250, '{8'd0, 8'd1, 8'd0});
        send_item(KIND_LOAD, 8'd200, '{8'd254, 8'd255, 8'd255});
        send_item(KIND_PIXEL, 8'd11, '{8'd0, 8'd0, 8'd0});

        send_random(650);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hdl/npci_pkg.sv
hdl/npci_cell.sv
hdl/nearest_palette_color_index_top.sv
sim/palette_match_checker.sv
sim/nearest_palette_color_index_top_tb.sv
